/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define KEI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kei assertion failed");

// next-cycle implication, off during reset
`define KEI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kei assertion failed");

`endif

/* rtl/core/kei_pkg.sv */
// ----------------------------------------------------------------------------
// kei_pkg
// Types and constants of the keyframe interpolator.
// ----------------------------------------------------------------------------
package kei_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT, CMD_CHANGE, CMD_DELETE, CMD_QUERY
  } cmd_t;

  localparam logic [6:0] APPEND_IDX = 7'd64;

  localparam logic [2:0] EASE_LINEAR = 3'd0;
  localparam logic [2:0] EASE_SINE   = 3'd1;
  localparam logic [2:0] EASE_CUBIC  = 3'd2;
  localparam logic [2:0] EASE_RCUBIC = 3'd3;
  localparam logic [2:0] EASE_FREEZE = 3'd4;
  localparam logic [2:0] EASE_HIDE   = 3'd5;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_HIDDEN = 2'd2;

  // sine polynomial coefficients, Q30
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef logic signed [31:0] comp_t;
  typedef comp_t [2:0] vec_t;

  typedef struct packed {
    logic [15:0] dur;
    logic [2:0]  easing;
    vec_t        pos;
    vec_t        scale;
  } key_t;

  typedef enum logic [1:0] {LD_HOLD, LD_PREV, LD_NEXT, LD_NEW} load_sel_t;

  typedef struct packed {
    logic act;
    logic found;
  } wave_t;

  typedef enum logic [2:0] {T_IDLE, T_SCAN, T_POS, T_SCALE, T_DONE} ctl_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV, B_SQ, B_CU, B_CUR, B_XX, B_X2, B_PM, B_PR,
    B_SX, B_SR, B_SS, B_SSR, B_MUL, B_ADD, B_DONE
  } blend_state_t;

  // Horner coefficients after the C9 seed
  function automatic logic [30:0] sin_coef(input logic [1:0] i);
    logic [30:0] c;
    case (i)
      2'd0:    c = SIN_C7;
      2'd1:    c = SIN_C5;
      2'd2:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/kei_cell.sv */
// ----------------------------------------------------------------------------
// kei_cell
// One key slot of the chain: holds a key, shifts with its neighbors on
// insert and delete, and passes the running duration sum on a query.
// ----------------------------------------------------------------------------
module kei_cell #(
  parameter int SUM_W = 23
) (
  input  logic                clk,
  input  logic                rst,
  input  kei_pkg::load_sel_t  sel,
  input  kei_pkg::key_t       key_new,
  input  kei_pkg::key_t       key_prev,
  input  kei_pkg::key_t       key_next,
  input  logic                key_valid,
  input  logic [15:0]         frame,
  input  kei_pkg::wave_t      wave_in,
  input  logic [SUM_W-1:0]    cum_in,
  output kei_pkg::wave_t      wave_out,
  output logic [SUM_W-1:0]    cum_out,
  output kei_pkg::key_t       key,
  output logic                hit,
  output logic [15:0]         step
);
  import kei_pkg::*;

  logic [SUM_W-1:0] cum_here;

  assign cum_here = cum_in + SUM_W'(key.dur);
  assign hit = wave_in.act && !wave_in.found && key_valid &&
               (SUM_W'(frame) < cum_here);
  assign step = 16'(SUM_W'(frame) - cum_in);

  always_ff @(posedge clk) begin
    case (sel)
      LD_PREV: key <= key_prev;
      LD_NEXT: key <= key_next;
      LD_NEW:  key <= key_new;
      default: key <= key;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out.act   <= wave_in.act;
      wave_out.found <= wave_in.found | hit;
    end
  end

  always_ff @(posedge clk) begin
    cum_out <= key_valid ? cum_here : cum_in;
  end

endmodule

/* rtl/core/kei_div.sv */
// ----------------------------------------------------------------------------
// kei_div
// Restoring divider, one quotient bit per cycle: (num << FB) / den,
// clamped to one in Q(FB).
// ----------------------------------------------------------------------------
module kei_div #(
  parameter int FB = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [FB:0] quo
);
  localparam int NW = 17 + FB;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic [NW-1:0] ONE = NW'(1) << FB;

  logic [NW-1:0]   dvd;
  logic [NW-1:0]   q;
  logic [16:0]     rem;
  logic [15:0]     den_q;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [16:0]     rem_sh;
  logic [17:0]     diff;

  assign rem_sh = {rem[15:0], dvd[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= {num, FB'(0)};
      rem   <= '0;
      q     <= '0;
      den_q <= den;
    end else if (run) begin
      dvd <= dvd << 1;
      if (!diff[17]) begin
        rem <= diff[16:0];
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

  assign quo = (q > ONE) ? ONE[FB:0] : q[FB:0];

endmodule

/* rtl/core/kei_blend.sv */
// ----------------------------------------------------------------------------
// kei_blend
// Eases one three-component vector from a toward b: divide for t, shape the
// weight on a shared registered multiplier, then blend each component.
// ----------------------------------------------------------------------------
module kei_blend #(
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  kei_pkg::vec_t a,
  input  kei_pkg::vec_t b,
  input  logic [2:0]    easing,
  input  logic [16:0]   num,
  input  logic [15:0]   dur,
  output logic          done,
  output kei_pkg::vec_t res
);
  import kei_pkg::*;

  localparam int MW = 34;
  localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;
  localparam logic signed [35:0] SAT_HI = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] SAT_LO = -36'sh0_8000_0000;

  blend_state_t state, state_next;

  vec_t        a_q, b_q;
  logic [2:0]  e_q;
  logic [FB:0] v, w;
  logic [30:0] x, x2, p, s;
  logic [1:0]  pc, c;

  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] prod;

  logic        div_start, div_done;
  logic [FB:0] quo;
  logic [FB:0] c3;
  logic [31:0] s_raw;
  logic [FB:0] w_raw;
  logic signed [35:0] r;

  kei_div #(.FB(FB)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (dur),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  assign c3    = prod[FB +: FB + 1];
  assign s_raw = prod[61:30];
  assign w_raw = prod[60-FB +: FB + 1];
  assign r     = 36'(a_q[c]) + 36'(prod >>> FB);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    ma         = '0;
    mb         = '0;
    done       = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (start) begin
          if (a == b || easing > EASE_HIDE) begin
            state_next = B_DONE;
          end else begin
            div_start  = 1'b1;
            state_next = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (div_done) begin
          unique case (e_q)
            EASE_CUBIC, EASE_RCUBIC: state_next = B_SQ;
            EASE_SINE:               state_next = B_XX;
            default:                 state_next = B_MUL;
          endcase
        end
      end
      B_SQ: begin
        ma = MW'(v);
        mb = MW'(v);
        state_next = B_CU;
      end
      B_CU: begin
        ma = MW'(c3);
        mb = MW'(v);
        state_next = B_CUR;
      end
      B_CUR: state_next = B_MUL;
      B_XX: begin
        ma = MW'(x);
        mb = MW'(x);
        state_next = B_X2;
      end
      B_X2: state_next = B_PM;
      B_PM: begin
        ma = MW'(p);
        mb = MW'(x2);
        state_next = B_PR;
      end
      B_PR: state_next = (pc == 2'd3) ? B_SX : B_PM;
      B_SX: begin
        ma = MW'(p);
        mb = MW'(x);
        state_next = B_SR;
      end
      B_SR: state_next = B_SS;
      B_SS: begin
        ma = MW'(s);
        mb = MW'(s);
        state_next = B_SSR;
      end
      B_SSR: state_next = B_MUL;
      B_MUL: begin
        ma = MW'(b_q[c]) - MW'(a_q[c]);
        mb = MW'(w);
        state_next = B_ADD;
      end
      B_ADD: state_next = (c == 2'd2) ? B_DONE : B_MUL;
      B_DONE: begin
        done       = 1'b1;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        a_q <= a;
        b_q <= b;
        e_q <= easing;
        c   <= '0;
        if (a == b) begin
          res <= a;
        end else begin
          res <= '0;
        end
      end
      B_DIV: begin
        w  <= (e_q == EASE_LINEAR) ? quo : ONE;
        v  <= (e_q == EASE_RCUBIC) ? ONE - quo : quo;
        x  <= 31'(quo) << (30 - FB);
      end
      B_CUR: w <= (e_q == EASE_CUBIC) ? c3 : ONE - c3;
      B_X2: begin
        x2 <= prod[60:30];
        p  <= SIN_C9;
        pc <= '0;
      end
      B_PR: begin
        p  <= sin_coef(pc) - prod[60:30];
        pc <= pc + 1'b1;
      end
      B_SR: s <= (s_raw > 32'(Q30_ONE)) ? Q30_ONE : s_raw[30:0];
      B_SSR: w <= (w_raw > ONE) ? ONE : w_raw;
      B_ADD: begin
        if (r > SAT_HI) begin
          res[c] <= comp_t'(SAT_HI[31:0]);
        end else if (r < SAT_LO) begin
          res[c] <= comp_t'(SAT_LO[31:0]);
        end else begin
          res[c] <= r[31:0];
        end
        c <= c + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/keyframe_eased_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_eased_interpolator
// Keyframe table in a chain of key cells with an eased blend unit.
// ----------------------------------------------------------------------------
// One command channel: an item is taken when start is high and busy is low.
// Commands insert/append, change and delete a key, or query a frame.
// Each item gives one result, shown for a single cycle with done high; the
// receiver cannot hold it off. busy stays high until that cycle has passed,
// so the next item can be taken in the cycle after done.
// Edits: the cells shift into place in the accept cycle; the result follows
// in the cycle after accept.
// Query: a sum wave runs down the cell chain, one cell per cycle, and a
// found key then takes two blend passes (position, then scale), each a
// serial divide followed by weight shaping and blending.
// A query landing on step 0 of a later key, or out of range, skips blending.
// Reset clears the key count, so the table reads as empty; key contents
// are kept as garbage and never read before being written.
// ----------------------------------------------------------------------------
module keyframe_eased_interpolator #(
  parameter int MAX_KEYS      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command,
  input  logic [6:0]           key_index,
  input  logic [15:0]          frames,
  input  logic [2:0]           key_type,
  input  kei_pkg::comp_t       pos_x,
  input  kei_pkg::comp_t       pos_y,
  input  kei_pkg::comp_t       pos_z,
  input  kei_pkg::comp_t       scale_x,
  input  kei_pkg::comp_t       scale_y,
  input  kei_pkg::comp_t       scale_z,
  output logic                 done,
  output logic [1:0]           status,
  output kei_pkg::comp_t       out_pos_x,
  output kei_pkg::comp_t       out_pos_y,
  output kei_pkg::comp_t       out_pos_z,
  output kei_pkg::comp_t       out_scale_x,
  output kei_pkg::comp_t       out_scale_y,
  output kei_pkg::comp_t       out_scale_z,
  output logic [5:0]           found_key
);
  import kei_pkg::*;

  localparam int IW    = $clog2(MAX_KEYS);
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int SUM_W = 16 + CW;
  localparam int EW    = CW + 7;

  ctl_state_t state, state_next;

  logic [CW-1:0] key_count;
  logic [CW-1:0] scan_cnt;
  logic          accept, is_query;
  logic          ins_ok, idx_ok, edit_ok;
  logic [EW-1:0] idx_e, cnt_e, at_e;

  key_t        key_new;
  key_t        cell_key [MAX_KEYS];
  wave_t       wave     [MAX_KEYS];
  logic [SUM_W-1:0] cum [MAX_KEYS];
  logic        hit      [MAX_KEYS];
  logic [15:0] cstep    [MAX_KEYS];
  logic        kvalid   [MAX_KEYS];
  load_sel_t   sel      [MAX_KEYS];
  wave_t       wave_head;

  key_t        bus_cur, bus_prev;
  logic [15:0] bus_step;
  logic [IW-1:0] bus_idx;
  logic        any_hit;

  logic [15:0] q_frame;
  vec_t        q_pos, q_scale;
  logic        got;
  logic [IW-1:0] cap_k;
  logic [15:0] cap_step;
  key_t        cap_cur, cap_prev;
  logic        k0, step0_copy, scan_end;

  logic        bl_start, bl_done;
  logic        use_pos;
  logic        scale_go;
  vec_t        bl_a, bl_b, bl_res;
  logic [2:0]  bl_easing;
  logic [16:0] bl_num;

  vec_t        out_pos_q, out_scale_q;

  assign accept   = start && !busy;
  assign is_query = (cmd_t'(command) == CMD_QUERY);
  assign idx_e    = EW'(key_index);
  assign cnt_e    = EW'(key_count);
  assign ins_ok   = (key_count < CW'(MAX_KEYS)) &&
                    (key_index == APPEND_IDX || idx_e < cnt_e);
  assign idx_ok   = idx_e < cnt_e;
  assign at_e     = (key_index == APPEND_IDX) ? cnt_e : idx_e;

  always_comb begin
    unique case (cmd_t'(command)) inside
      CMD_INSERT: edit_ok = ins_ok;
      CMD_CHANGE, CMD_DELETE: edit_ok = idx_ok;
      default:    edit_ok = 1'b0;
    endcase
  end

  assign key_new.dur    = frames;
  assign key_new.easing = key_type;
  assign key_new.pos    = {pos_z, pos_y, pos_x};
  assign key_new.scale  = {scale_z, scale_y, scale_x};

  // per-cell load select for the edit taken this cycle
  always_comb begin
    for (int i = 0; i < MAX_KEYS; i++) begin
      sel[i]    = LD_HOLD;
      kvalid[i] = EW'(i) < cnt_e;
      if (accept) begin
        unique case (cmd_t'(command))
          CMD_INSERT: begin
            if (ins_ok && EW'(i) == at_e) begin
              sel[i] = LD_NEW;
            end else if (ins_ok && EW'(i) > at_e && EW'(i) <= cnt_e) begin
              sel[i] = LD_PREV;
            end
          end
          CMD_CHANGE: begin
            if (idx_ok && EW'(i) == idx_e) sel[i] = LD_NEW;
          end
          CMD_DELETE: begin
            if (idx_ok && EW'(i) >= idx_e && EW'(i) + 1'b1 < cnt_e) sel[i] = LD_NEXT;
          end
          default: ;
        endcase
      end
    end
  end

  assign wave_head.act   = (state == T_SCAN) && (scan_cnt == '0);
  assign wave_head.found = 1'b0;

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    kei_cell #(.SUM_W(SUM_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .sel       (sel[g]),
      .key_new   (key_new),
      .key_prev  (cell_key[(g == 0) ? 0 : g - 1]),
      .key_next  (cell_key[(g == MAX_KEYS - 1) ? g : g + 1]),
      .key_valid (kvalid[g]),
      .frame     (q_frame),
      .wave_in   ((g == 0) ? wave_head : wave[(g == 0) ? 0 : g - 1]),
      .cum_in    ((g == 0) ? '0 : cum[(g == 0) ? 0 : g - 1]),
      .wave_out  (wave[g]),
      .cum_out   (cum[g]),
      .key       (cell_key[g]),
      .hit       (hit[g]),
      .step      (cstep[g])
    );
  end

  // only one cell hits in any cycle
  always_comb begin
    bus_cur  = '0;
    bus_prev = '0;
    bus_step = '0;
    bus_idx  = '0;
    any_hit  = 1'b0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (hit[i]) begin
        bus_cur  = bus_cur | cell_key[i];
        bus_prev = bus_prev | cell_key[(i == 0) ? 0 : i - 1];
        bus_step = bus_step | cstep[i];
        bus_idx  = bus_idx | IW'(i);
        any_hit  = 1'b1;
      end
    end
  end

  assign k0         = (cap_k == '0);
  assign step0_copy = !k0 && (cap_step == '0);
  assign scan_end   = (state == T_SCAN) && (scan_cnt == CW'(MAX_KEYS));

  // scale pass starts once the blend unit is back in idle
  assign use_pos   = (state == T_SCAN);
  assign bl_a      = use_pos ? (k0 ? q_pos : cap_prev.pos)
                             : (k0 ? q_scale : cap_prev.scale);
  assign bl_b      = use_pos ? cap_cur.pos : cap_cur.scale;
  assign bl_easing = (use_pos && k0) ? EASE_LINEAR : cap_cur.easing;
  assign bl_num    = use_pos ? 17'(cap_step) + 17'd1 : 17'(cap_step);
  assign bl_start  = (scan_end && got && !step0_copy) || scale_go;

  kei_blend #(.FB(FRACTION_BITS)) u_blend (
    .clk    (clk),
    .rst    (rst),
    .start  (bl_start),
    .a      (bl_a),
    .b      (bl_b),
    .easing (bl_easing),
    .num    (bl_num),
    .dur    (cap_cur.dur),
    .done   (bl_done),
    .res    (bl_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (accept) state_next = is_query ? T_SCAN : T_DONE;
      T_SCAN:  if (scan_end) state_next = bl_start ? T_POS : T_DONE;
      T_POS:   if (bl_done) state_next = T_SCALE;
      T_SCALE: if (bl_done) state_next = T_DONE;
      T_DONE:  state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  assign busy = (state != T_IDLE);
  assign done = (state == T_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      got       <= 1'b0;
      scan_cnt  <= '0;
      scale_go  <= 1'b0;
    end else begin
      scale_go <= (state == T_POS) && bl_done;
      if (accept) begin
        scan_cnt <= '0;
        got      <= 1'b0;
        if (cmd_t'(command) == CMD_INSERT && ins_ok) key_count <= key_count + 1'b1;
        if (cmd_t'(command) == CMD_DELETE && idx_ok) key_count <= key_count - 1'b1;
      end else if (state == T_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
        if (any_hit) got <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_frame <= frames;
      q_pos   <= key_new.pos;
      q_scale <= key_new.scale;
    end
    if (state == T_SCAN && any_hit) begin
      cap_k    <= bus_idx;
      cap_step <= bus_step;
      cap_cur  <= bus_cur;
      cap_prev <= bus_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= edit_ok ? ST_DONE : ST_REJECT;
      out_pos_q   <= '0;
      out_scale_q <= '0;
      found_key   <= '0;
    end else if (scan_end) begin
      if (!got) begin
        status <= ST_REJECT;
      end else begin
        status    <= (cap_cur.easing == EASE_HIDE) ? ST_HIDDEN : ST_DONE;
        found_key <= 6'(cap_k);
        if (step0_copy) begin
          out_pos_q   <= cap_prev.pos;
          out_scale_q <= cap_prev.scale;
        end
      end
    end else if (state == T_POS && bl_done) begin
      out_pos_q <= bl_res;
    end else if (state == T_SCALE && bl_done) begin
      out_scale_q <= bl_res;
    end
  end

  assign out_pos_x   = out_pos_q[0];
  assign out_pos_y   = out_pos_q[1];
  assign out_pos_z   = out_pos_q[2];
  assign out_scale_x = out_scale_q[0];
  assign out_scale_y = out_scale_q[1];
  assign out_scale_z = out_scale_q[2];

endmodule

/* rtl/core/kei_checker.sv */
// ----------------------------------------------------------------------------
// kei_checker
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kei_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // a taken item keeps the block busy until its result
  `KEI_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // one result cycle, then free again
  `KEI_ASSERT_NEXT(a_done_release, done, !busy && !done)
  // no result without an item in flight
  `KEI_ASSERT_IMPL(a_done_in_flight, done, busy)

endmodule

bind keyframe_eased_interpolator kei_checker u_kei_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

/* tb/tb_keyframe_eased_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_eased_interpolator
// Drives insert, change, delete and query items into the keyframe table and
// checks each result against a cycle-free model of the table and the eased
// blend, with random idle gaps on the command side.
// ----------------------------------------------------------------------------
module tb_keyframe_eased_interpolator;
  import kei_pkg::*;

  localparam int NKEYS = 64;
  localparam int FB = 16;
  localparam longint unsigned UNIT = 64'd1 << FB;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    cmd_t        cmd;
    logic [6:0]  idx;
    logic [15:0] frames;
    logic [2:0]  easing;
    vec_t        pos;
    vec_t        scale;
  } key_item_t;

  typedef struct {
    logic [1:0] status;
    vec_t       pos;
    vec_t       scale;
    logic [5:0] key;
  } blend_res_t;

  logic clk, rst, start, busy, done;
  logic [1:0] command;
  logic [6:0] key_index;
  logic [15:0] frames;
  logic [2:0] key_type;
  comp_t pos_x, pos_y, pos_z, scale_x, scale_y, scale_z;
  logic [1:0] status;
  comp_t out_pos_x, out_pos_y, out_pos_z, out_scale_x, out_scale_y, out_scale_z;
  logic [5:0] found_key;

  keyframe_eased_interpolator DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // table model
  int unsigned tbl_count;
  logic [15:0] tbl_dur [NKEYS];
  logic [2:0]  tbl_ease [NKEYS];
  vec_t        tbl_pos [NKEYS];
  vec_t        tbl_scale [NKEYS];

  key_item_t   pending_items[$];
  blend_res_t  expected_results[$];
  int          error_count = 0;
  bit          stim_loaded = 0;

  // generator-side mirror of durations, to aim queries inside the table
  int unsigned gen_dur[$];

  function automatic longint unsigned sine_sq(longint unsigned t);
    longint unsigned x, x2, p, s, w;
    x = t << (30 - FB);
    x2 = (x * x) >> 30;
    p = SIN_C9;
    p = SIN_C7 - ((p * x2) >> 30);
    p = SIN_C5 - ((p * x2) >> 30);
    p = SIN_C3 - ((p * x2) >> 30);
    p = SIN_C1 - ((p * x2) >> 30);
    s = (p * x) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    w = (s * s) >> (60 - FB);
    return (w > UNIT) ? UNIT : w;
  endfunction

  function automatic longint unsigned ease_w(logic [2:0] e, int unsigned num,
                                             int unsigned dur);
    longint unsigned t, u;
    t = (longint'(num) << FB) / dur;
    if (t > UNIT) t = UNIT;
    case (e)
      EASE_LINEAR: return t;
      EASE_SINE:   return sine_sq(t);
      EASE_CUBIC:  return (((t * t) >> FB) * t) >> FB;
      EASE_RCUBIC: begin
        u = UNIT - t;
        return UNIT - ((((u * u) >> FB) * u) >> FB);
      end
      default:     return UNIT;
    endcase
  endfunction

  function automatic vec_t blend_vec(vec_t a, vec_t b, logic [2:0] e,
                                     int unsigned num, int unsigned dur);
    vec_t o;
    longint unsigned w;
    longint d, r;
    if (a == b) return a;
    if (e > EASE_HIDE) return '0;
    w = ease_w(e, num, dur);
    for (int i = 0; i < 3; i++) begin
      d = longint'(b[i]) - longint'(a[i]);
      r = longint'(a[i]) + ((d * longint'(w)) >>> FB);  // floor division
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      o[i] = comp_t'(r);
    end
    return o;
  endfunction

  function automatic blend_res_t apply_item(key_item_t it);
    blend_res_t res;
    int unsigned at, total, cum, k, step, dur;
    logic [2:0] e;
    res = '{status: ST_REJECT, pos: '0, scale: '0, key: '0};
    case (it.cmd)
      CMD_INSERT: if (tbl_count < NKEYS && (it.idx == APPEND_IDX || it.idx < tbl_count)) begin
        at = (it.idx == APPEND_IDX) ? tbl_count : it.idx;
        for (int i = tbl_count; i > at; i--) begin
          tbl_dur[i] = tbl_dur[i-1]; tbl_ease[i] = tbl_ease[i-1];
          tbl_pos[i] = tbl_pos[i-1]; tbl_scale[i] = tbl_scale[i-1];
        end
        tbl_dur[at] = it.frames; tbl_ease[at] = it.easing;
        tbl_pos[at] = it.pos; tbl_scale[at] = it.scale;
        tbl_count++;
        res.status = ST_DONE;
      end
      CMD_CHANGE: if (it.idx < tbl_count) begin
        tbl_dur[it.idx] = it.frames; tbl_ease[it.idx] = it.easing;
        tbl_pos[it.idx] = it.pos; tbl_scale[it.idx] = it.scale;
        res.status = ST_DONE;
      end
      CMD_DELETE: if (it.idx < tbl_count) begin
        for (int i = it.idx; i + 1 < tbl_count; i++) begin
          tbl_dur[i] = tbl_dur[i+1]; tbl_ease[i] = tbl_ease[i+1];
          tbl_pos[i] = tbl_pos[i+1]; tbl_scale[i] = tbl_scale[i+1];
        end
        tbl_count--;
        res.status = ST_DONE;
      end
      default: begin
        total = 0;
        for (int i = 0; i < tbl_count; i++) total += tbl_dur[i];
        if (total == 0 || it.frames >= total) return res;
        cum = 0; k = 0;
        for (int i = 0; i < tbl_count; i++) begin
          k = i;
          cum += tbl_dur[i];
          if (it.frames < cum) break;
        end
        dur = tbl_dur[k];
        step = it.frames - (cum - dur);
        e = tbl_ease[k];
        if (k != 0 && step == 0) begin
          res.pos = tbl_pos[k-1];
          res.scale = tbl_scale[k-1];
        end else if (k == 0) begin
          // key 0 starts from the current pose carried in the item
          res.pos = blend_vec(it.pos, tbl_pos[0], EASE_LINEAR, step + 1, dur);
          res.scale = blend_vec(it.scale, tbl_scale[0], e, step, dur);
        end else begin
          res.pos = blend_vec(tbl_pos[k-1], tbl_pos[k], e, step + 1, dur);
          res.scale = blend_vec(tbl_scale[k-1], tbl_scale[k], e, step, dur);
        end
        res.status = (e == EASE_HIDE) ? ST_HIDDEN : ST_DONE;
        res.key = k[5:0];
      end
    endcase
    return res;
  endfunction

  function automatic comp_t pick_comp();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sh0001_0000;
      3: return '0;
      4: return -32'sh1;
      5, 6: return comp_t'($urandom_range(0, 8) << 16) - comp_t'(4 << 16);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic vec_t pick_vec();
    vec_t v;
    for (int i = 0; i < 3; i++) v[i] = pick_comp();
    return v;
  endfunction

  task automatic push_item(cmd_t c, logic [6:0] idx, logic [15:0] fr,
                           logic [2:0] e, vec_t p, vec_t s);
    key_item_t it;
    it = '{cmd: c, idx: idx, frames: fr, easing: e, pos: p, scale: s};
    pending_items.insert(pending_items.size(), it);
    case (c)
      CMD_INSERT: if (gen_dur.size() < NKEYS && (idx == APPEND_IDX || idx < gen_dur.size()))
        gen_dur.insert((idx == APPEND_IDX) ? gen_dur.size() : idx, fr);
      CMD_CHANGE: if (idx < gen_dur.size()) gen_dur[idx] = fr;
      CMD_DELETE: if (idx < gen_dur.size()) gen_dur.delete(idx);
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_dur();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 10));
    endcase
  endfunction

  task automatic push_query();
    int unsigned total;
    logic [15:0] fr;
    total = 0;
    foreach (gen_dur[i]) total += gen_dur[i];
    if (total > 0 && $urandom_range(0, 9) != 0)
      fr = 16'($urandom_range(0, (total > 65536 ? 65535 : total - 1)));
    else
      fr = 16'($urandom);
    push_item(CMD_QUERY, 7'($urandom), fr, 3'($urandom), pick_vec(), pick_vec());
  endtask

  // stimulus
  initial begin
    vec_t vmax, vmin, vz;
    int n;
    vmax = {3{32'sh7fff_ffff}};
    vmin = {3{32'sh8000_0000}};
    vz = '0;
    // directed: empty table, extremes, every easing, edits and rejects
    push_item(CMD_QUERY, 7'd0, 16'd0, EASE_LINEAR, vz, vz);
    push_item(CMD_DELETE, 7'd0, 16'd0, EASE_LINEAR, vz, vz);
    push_item(CMD_CHANGE, 7'd0, 16'd1, EASE_LINEAR, vz, vz);
    push_item(CMD_INSERT, 7'd0, 16'd4, EASE_LINEAR, vmax, vmin);
    push_item(CMD_INSERT, APPEND_IDX, 16'd4, EASE_LINEAR, vmax, vmin);
    for (int e = 0; e < 8; e++)
      push_item(CMD_INSERT, APPEND_IDX, 16'd3, 3'(e), (e[0] ? vmin : vmax),
                (e[0] ? vmax : vmin));
    push_item(CMD_QUERY, 7'd0, 16'd0, EASE_LINEAR, vmin, vmax);  // key 0, far pose
    push_item(CMD_QUERY, 7'd0, 16'd2, EASE_LINEAR, vmax, vmin);  // key 0, equal ends
    push_item(CMD_QUERY, 7'd0, 16'd4, EASE_LINEAR, vz, vz);      // step 0 of key 1
    for (int f = 9; f < 33; f += 3)
      push_item(CMD_QUERY, 7'd127, 16'(f), 3'd7, vz, vz);
    push_item(CMD_QUERY, 7'd0, 16'hffff, EASE_LINEAR, vz, vz);   // out of range
    push_item(CMD_INSERT, 7'd100, 16'd1, EASE_LINEAR, vz, vz);
    push_item(CMD_INSERT, 7'd1, 16'd0, EASE_HIDE, vmax, vmax);
    push_item(CMD_CHANGE, 7'd2, 16'hffff, EASE_CUBIC, vmin, vmax);
    push_item(CMD_DELETE, 7'd1, 16'd0, EASE_LINEAR, vz, vz);
    // random: inserts only until the table holds 40 keys, then mixed traffic
    n = 0;
    while (n < 1700) begin
      int sel;
      logic [6:0] idx;
      sel = $urandom_range(0, 99);
      if (gen_dur.size() < 40 && n < 200) sel = 60;
      if ($urandom_range(0, 9) == 0) idx = 7'($urandom);
      else if (gen_dur.size() > 0 && $urandom_range(0, 1) == 0)
        idx = 7'($urandom_range(0, gen_dur.size() - 1));
      else idx = APPEND_IDX;
      if (sel < 50) push_query();
      else if (sel < 77) push_item(CMD_INSERT, idx, pick_dur(), 3'($urandom), pick_vec(),
                                   pick_vec());
      else if (sel < 89) push_item(CMD_CHANGE, idx, pick_dur(), 3'($urandom), pick_vec(),
                                   pick_vec());
      else push_item(CMD_DELETE, idx, 16'($urandom), 3'($urandom), pick_vec(), pick_vec());
      n++;
    end
    stim_loaded = 1;
  end

  // driver
  key_item_t cur_item;
  int idle_left;
  int burst_left;

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(5, 30);
    return $urandom_range(0, 17);
  endfunction

  always @(posedge clk) begin
    bit free;
    if (rst) begin
      start <= 1'b0;
      command <= '0; key_index <= '0; frames <= '0; key_type <= '0;
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
      scale_x <= '0; scale_y <= '0; scale_z <= '0;
      idle_left = 0;
      burst_left = 0;
    end else begin
      free = !start;
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), apply_item(cur_item));
        idle_left = draw_gap();
        free = 1;
      end else if (!start && idle_left > 0) begin
        idle_left--;
      end
      if (free && idle_left == 0 && pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        start <= 1'b1;
        command <= cur_item.cmd; key_index <= cur_item.idx;
        frames <= cur_item.frames; key_type <= cur_item.easing;
        pos_x <= cur_item.pos[0]; pos_y <= cur_item.pos[1]; pos_z <= cur_item.pos[2];
        scale_x <= cur_item.scale[0]; scale_y <= cur_item.scale[1];
        scale_z <= cur_item.scale[2];
      end else if (free) begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  // monitor
  always @(posedge clk) begin
    blend_res_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("result with no item outstanding");
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (out_pos_x !== want.pos[0]) report_mismatch("out_pos_x", out_pos_x, want.pos[0]);
        if (out_pos_y !== want.pos[1]) report_mismatch("out_pos_y", out_pos_y, want.pos[1]);
        if (out_pos_z !== want.pos[2]) report_mismatch("out_pos_z", out_pos_z, want.pos[2]);
        if (out_scale_x !== want.scale[0])
          report_mismatch("out_scale_x", out_scale_x, want.scale[0]);
        if (out_scale_y !== want.scale[1])
          report_mismatch("out_scale_y", out_scale_y, want.scale[1]);
        if (out_scale_z !== want.scale[2])
          report_mismatch("out_scale_z", out_scale_z, want.scale[2]);
        if (found_key !== want.key) report_mismatch("found_key", found_key, want.key);
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_keyframe_eased_interpolator: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (stim_loaded);
    do @(negedge clk);
    while (pending_items.size() > 0 || start || expected_results.size() > 0);
    repeat (200) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("tb_keyframe_eased_interpolator: clean");
    else
      $display("tb_keyframe_eased_interpolator: errors");
    $finish;
  end

endmodule
